FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the detector RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, off while reset is asserted
`define PDL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pdl assertion failed");
// Checked property, also during reset
`define PDL_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pdl assertion failed");
`else
`define PDL_ASSERT(lbl, clk, rst_n, prop)
`define PDL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/core/pdl_pkg.sv
// Shared types and constants of the PDM loud sound detector.
`default_nettype none

package pdl_pkg;

  // Field widths
  localparam int PdmW     = 16;
  localparam int EnvW     = 24;
  localparam int AccW     = 32;
  localparam int KeepW    = 16;
  localparam int WinW     = 16;
  localparam int ThreshW  = 24;
  localparam int CfgW     = 24;
  localparam int CfgIdxW  = 2;
  localparam int FracW    = 8;

  // Default parameter values
  localparam int BlockWordsDef = 20;
  localparam int WordBitsDef   = 16;

  // Register reset values
  localparam logic [KeepW-1:0]   KeepReset   = 16'd62259;
  localparam logic [WinW-1:0]    WindowReset = 16'd1000;
  localparam logic [ThreshW-1:0] ThreshReset = 24'd31000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgKeep   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWindow = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgThresh = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture word, form saturated level sum
    logic lmul;    // level leak multiply
    logic esum;    // envelope plus level magnitude
    logic emul;    // envelope leak multiply
    logic commit;  // block/window update, load result register
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/pdl_in_if.sv
// Input channel: one PDM word per beat.
`default_nettype none

interface pdl_in_if;
  import pdl_pkg::*;

  logic            valid;
  logic            ready;
  logic [PdmW-1:0] pdm_word;

  modport source (output valid, output pdm_word, input ready);
  modport sink   (input valid, input pdm_word, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pdl_out_if.sv
// Output channel: one envelope result per beat.
`default_nettype none

interface pdl_out_if;
  import pdl_pkg::*;

  logic            valid;
  logic            ready;
  logic [EnvW-1:0] envelope_level;
  logic            block_end;
  logic            detected;

  modport source (output valid, output envelope_level, output block_end,
                  output detected, input ready);
  modport sink   (input valid, input envelope_level, input block_end,
                  input detected, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pdl_ctrl.sv
// Sequencer of the detector: steps each word through the shared datapath.
`default_nettype none
`include "assert_macros.svh"

module pdl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output pdl_pkg::cmd_t      cmd_o
);
  import pdl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LMUL = 5'b00010,
    S_ESUM = 5'b00100,
    S_EMUL = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_LMUL;
        end
      end
      S_LMUL: begin
        cmd_o.lmul = 1'b1;
        state_d    = S_ESUM;
      end
      S_ESUM: begin
        cmd_o.esum = 1'b1;
        state_d    = S_EMUL;
      end
      S_EMUL: begin
        cmd_o.emul = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        // wait here while the result register still holds an untaken beat
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A new result appears only from the commit step
  `PDL_ASSERT(a_valid_from_commit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))
  // Commit never overwrites a beat that was not taken
  `PDL_ASSERT(a_commit_free, clk_i, rst_ni, cmd_o.commit |-> slot_free)
  // An accepted word goes straight into the level multiply
  `PDL_ASSERT(a_accept_lmul, clk_i, rst_ni, accept |=> (state_q == S_LMUL))
  // No word is taken while one is being worked on
  `PDL_ASSERT_ALWAYS(a_ready_idle_only, clk_i, in_ready_o |-> (state_q == S_IDLE || !rst_ni))

endmodule

`default_nettype wire

FILE: rtl/core/pdl_datapath.sv
// Datapath of the detector: popcount, leaky level and envelope, block/window.
`default_nettype none

module pdl_datapath #(
  parameter int BlockWords = pdl_pkg::BlockWordsDef,
  parameter int WordBits   = pdl_pkg::WordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pdl_pkg::cmd_t                 cmd_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [pdl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [pdl_pkg::CfgW-1:0]      cfg_wdata_i,
  input  wire logic [pdl_pkg::PdmW-1:0]      pdm_word_i,
  output logic      [pdl_pkg::EnvW-1:0]      envelope_level_o,
  output logic                               block_end_o,
  output logic                               detected_o
);
  import pdl_pkg::*;

  localparam int IdxW     = (BlockWords > 1) ? $clog2(BlockWords) : 1;
  localparam int OnesW    = $clog2(PdmW + 1);
  localparam int SampW    = OnesW + 2;
  localparam int HalfBits = WordBits / 2;
  localparam int ProdW    = AccW + KeepW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(BlockWords - 1);

  // Configuration registers
  logic [KeepW-1:0]   keep_q;
  logic [WinW-1:0]    window_q;
  logic [ThreshW-1:0] thresh_q;

  // Running state
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [AccW-1:0]    level_q, level_d;
  logic [AccW-1:0]    env_q, env_d;
  logic [WinW-1:0]    bcnt_q, bcnt_d;
  logic [AccW-1:0]    peak_q, peak_d;

  // Work registers
  logic [AccW-1:0]    op_q, op_d;
  logic               neg_q, neg_d;

  // Result register
  logic [EnvW-1:0]    res_env_q;
  logic               res_blk_q, res_det_q;
  logic               res_blk_d, res_det_d;

  logic [OnesW-1:0]        ones;
  logic signed [SampW-1:0] sample;
  logic [AccW:0]           lsum;
  logic [AccW-1:0]         lsat;
  logic [ProdW-1:0]        prod;
  logic [AccW-1:0]         scaled;
  logic [AccW:0]           esum;
  logic [WinW-1:0]         bcnt_inc;
  logic [AccW-1:0]         peak_new;

  // Population count of the low WordBits bits
  always_comb begin
    ones = '0;
    for (int i = 0; i < PdmW; i++) begin
      if (i < WordBits) ones = ones + OnesW'(pdm_word_i[i]);
    end
  end

  assign sample = $signed({2'b00, ones}) - SampW'(HalfBits);

  // Level plus sample, saturated to the signed 32-bit range
  assign lsum = {level_q[AccW-1], level_q}
              + {{(AccW + 1 - SampW - FracW){sample[SampW-1]}}, sample, {FracW{1'b0}}};
  always_comb begin
    if (lsum[AccW] != lsum[AccW-1]) begin
      lsat = lsum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      lsat = lsum[AccW-1:0];
    end
  end

  // Shared leak multiplier
  assign prod   = {{KeepW{1'b0}}, op_q} * {{AccW{1'b0}}, keep_q};
  assign scaled = prod[ProdW-1:KeepW];

  // Envelope plus level magnitude, saturated
  assign esum = {1'b0, env_q} + {1'b0, op_q};

  // Block and window bookkeeping
  assign bcnt_inc = bcnt_q + WinW'(1);
  assign peak_new = (env_q > peak_q) ? env_q : peak_q;

  always_comb begin
    op_d      = op_q;
    neg_d     = neg_q;
    level_d   = level_q;
    env_d     = env_q;
    idx_d     = idx_q;
    bcnt_d    = bcnt_q;
    peak_d    = peak_q;
    res_blk_d = 1'b0;
    res_det_d = 1'b0;
    if (cmd_i.load) begin
      neg_d = lsat[AccW-1];
      op_d  = lsat[AccW-1] ? (~lsat + AccW'(1)) : lsat;
    end
    if (cmd_i.lmul) begin
      // magnitude of the new level feeds the envelope
      op_d    = scaled;
      level_d = neg_q ? (~scaled + AccW'(1)) : scaled;
    end
    if (cmd_i.esum) begin
      op_d = esum[AccW] ? {AccW{1'b1}} : esum[AccW-1:0];
    end
    if (cmd_i.emul) begin
      env_d = scaled;
    end
    if (cmd_i.commit) begin
      if (idx_q == LastIdx) begin
        idx_d     = '0;
        res_blk_d = 1'b1;
        bcnt_d    = bcnt_inc;
        peak_d    = peak_new;
        if (bcnt_inc >= window_q) begin
          res_det_d = (peak_new[AccW-1:FracW] > thresh_q);
          peak_d    = '0;
          bcnt_d    = '0;
        end
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q   <= KeepReset;
      window_q <= WindowReset;
      thresh_q <= ThreshReset;
      idx_q    <= '0;
      level_q  <= '0;
      env_q    <= '0;
      bcnt_q   <= '0;
      peak_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgKeep:   keep_q   <= cfg_wdata_i[KeepW-1:0];
          CfgWindow: window_q <= cfg_wdata_i[WinW-1:0];
          CfgThresh: thresh_q <= cfg_wdata_i[ThreshW-1:0];
          default:   ;
        endcase
      end
      idx_q   <= idx_d;
      level_q <= level_d;
      env_q   <= env_d;
      bcnt_q  <= bcnt_d;
      peak_q  <= peak_d;
    end
  end

  // Work and result registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    neg_q <= neg_d;
    if (cmd_i.commit) begin
      res_env_q <= env_q[AccW-1:FracW];
      res_blk_q <= res_blk_d;
      res_det_q <= res_det_d;
    end
  end

  assign envelope_level_o = res_env_q;
  assign block_end_o      = res_blk_q;
  assign detected_o       = res_det_q;

endmodule

`default_nettype wire

FILE: rtl/core/pdm_loud_sound_detector_unit.sv
// Top level of the PDM loud sound detector.
`default_nettype none

// Each PDM word goes through these steps from acceptance to its result:
// the accepting cycle forms the saturated level sum, then the single shared
// 32x16 leak multiplier runs twice (level, then envelope) with the envelope
// add between them, and a last cycle updates the block and window counters
// and loads the result register. The next word is accepted as soon as that
// cycle is done, even while the previous result still waits in the output
// register; only when that register is still full at commit time does the
// word wait. Every result beat carries the envelope integer part, a block-end
// flag on the word that closes a block, and a detected flag on the word that
// closes a window whose peak envelope exceeded the threshold. Configuration
// writes take effect at once and should be made while no word is in flight.
module pdm_loud_sound_detector_unit #(
  parameter int BlockWords = pdl_pkg::BlockWordsDef,
  parameter int WordBits   = pdl_pkg::WordBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [pdl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pdl_pkg::CfgW-1:0]     cfg_wdata_i,
  pdl_in_if.sink                            pdm_i,
  pdl_out_if.source                         res_o
);
  import pdl_pkg::*;

  cmd_t cmd;
  logic in_ready;
  logic out_valid;

  // Sequencer
  pdl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pdm_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  pdl_datapath #(
    .BlockWords (BlockWords),
    .WordBits   (WordBits)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pdm_word_i       (pdm_i.pdm_word),
    .envelope_level_o (res_o.envelope_level),
    .block_end_o      (res_o.block_end),
    .detected_o       (res_o.detected)
  );

  assign pdm_i.ready = in_ready;
  assign res_o.valid = out_valid;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench of the PDM loud sound detector top level.
`timescale 1ns / 100ps

module tb;
  import pdl_pkg::*;

  localparam int CycleLimit = 500_000;
  localparam int NumPhases  = 12;
  localparam int PhaseWords = 120;

  // One result beat as the block should present it
  typedef struct packed {
    logic [EnvW-1:0] env_int;
    logic            block_end;
    logic            detected;
  } env_beat_t;

  // Predicts the envelope / block / window results and checks the output beats
  class loudness_scoreboard;
    int unsigned keep;
    int unsigned window;
    int unsigned thresh;
    int unsigned word_idx;
    int          level_q8;
    int unsigned env_q8;
    int unsigned blocks;
    int unsigned peak_q8;
    int unsigned errors;
    env_beat_t   env_expect_q[$];

    function new();
      keep     = 32'(KeepReset);
      window   = 32'(WindowReset);
      thresh   = 32'(ThreshReset);
      word_idx = 0;
      level_q8 = 0;
      env_q8   = 0;
      blocks   = 0;
      peak_q8  = 0;
      errors   = 0;
    endfunction

    function void set_config(int unsigned k, int unsigned w, int unsigned t);
      keep   = k & 32'hFFFF;
      window = w & 32'hFFFF;
      thresh = t & 32'hFF_FFFF;
    endfunction

    function int unsigned pending();
      return env_expect_q.size();
    endfunction

    // Run one accepted word through the leaky level/envelope and block logic
    function void note_word(logic [PdmW-1:0] w);
      longint          lsum;
      longint unsigned mag;
      longint unsigned scaled;
      longint unsigned esum;
      env_beat_t       beat;
      lsum = longint'(level_q8) + (longint'($countones(w)) - WordBitsDef / 2) * 256;
      if (lsum > 64'sh7FFF_FFFF) lsum = 64'sh7FFF_FFFF;
      if (lsum < -64'sh8000_0000) lsum = -64'sh8000_0000;
      // leak on the magnitude, truncating toward zero
      mag      = (lsum < 0) ? -lsum : lsum;
      scaled   = (mag * keep) >> 16;
      level_q8 = (lsum < 0) ? -int'(scaled) : int'(scaled);
      mag      = (level_q8 < 0) ? -longint'(level_q8) : longint'(level_q8);
      esum     = longint'(env_q8) + mag;
      if (esum > 64'hFFFF_FFFF) esum = 64'hFFFF_FFFF;
      env_q8   = int'((esum * keep) >> 16);
      beat.block_end = 1'b0;
      beat.detected  = 1'b0;
      // block close, peak tracking and window decision
      if (word_idx + 1 >= BlockWordsDef) begin
        word_idx       = 0;
        beat.block_end = 1'b1;
        blocks         = (blocks + 1) & 32'hFFFF;
        if (env_q8 > peak_q8) peak_q8 = env_q8;
        if (blocks >= window) begin
          beat.detected = ((peak_q8 >> FracW) > thresh);
          peak_q8       = 0;
          blocks        = 0;
        end
      end else begin
        word_idx = (word_idx + 1) & 32'hFF;
      end
      beat.env_int = EnvW'(env_q8 >> FracW);
      env_expect_q.push_back(beat);
    endfunction

    function void check_beat(logic [EnvW-1:0] env_int, logic block_end, logic detected);
      env_beat_t beat;
      if (env_expect_q.size() == 0) begin
        $error("result beat with nothing expected: envelope_level %0d", env_int);
        errors++;
        return;
      end
      beat = env_expect_q.pop_front();
      if (env_int !== beat.env_int) begin
        $error("envelope_level: expected %0d, got %0d", beat.env_int, env_int);
        errors++;
      end
      if (block_end !== beat.block_end) begin
        $error("block_end: expected %0b, got %0b", beat.block_end, block_end);
        errors++;
      end
      if (detected !== beat.detected) begin
        $error("detected: expected %0b, got %0b", beat.detected, detected);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;
  int                 cycle_count = 0;
  int                 src_gap_pct = 15;
  int                 sink_stall_pct = 57;
  loudness_scoreboard sb = new();

  pdl_in_if  pdm_if ();
  pdl_out_if res_if ();

  pdm_loud_sound_detector_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pdm_i       (pdm_if.sink),
    .res_o       (res_if.source)
  );

  always #4 clk_i = ~clk_i;

  // Receiver back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Beat monitor: note accepted words, check result beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pdm_if.valid && pdm_if.ready) sb.note_word(pdm_if.pdm_word);
      if (res_if.valid && res_if.ready) begin
        sb.check_beat(res_if.envelope_level, res_if.block_end, res_if.detected);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Present one word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(input logic [PdmW-1:0] w);
    if ($urandom_range(0, 99) < src_gap_pct) begin
      pdm_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_gap_pct);
    end
    pdm_if.valid    <= 1'b1;
    pdm_if.pdm_word <= w;
    @(posedge clk_i);
    while (!pdm_if.ready) @(posedge clk_i);
  endtask

  // Stop sending and let every expected beat come out
  task automatic drain(input int settle);
    pdm_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write all three registers back to back while idle
  task automatic write_regs(input logic [KeepW-1:0] keep, input logic [WinW-1:0] win,
                            input logic [ThreshW-1:0] thr);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgKeep;
    cfg_wdata_i <= {8'b0, keep};
    @(posedge clk_i);
    cfg_idx_i   <= CfgWindow;
    cfg_wdata_i <= {8'b0, win};
    @(posedge clk_i);
    cfg_idx_i   <= CfgThresh;
    cfg_wdata_i <= thr;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_config(32'(keep), 32'(win), 32'(thr));
  endtask

  // Word whose bits are set with probability dens/16
  function automatic logic [PdmW-1:0] pdm_burst(input int unsigned dens);
    logic [PdmW-1:0] w;
    for (int b = 0; b < PdmW; b++) w[b] = ($urandom_range(0, 15) < dens);
    return w;
  endfunction

  initial begin
    logic [PdmW-1:0] directed_words[22];
    int unsigned     keep_v;
    int unsigned     win_v;
    int unsigned     thr_v;
    int unsigned     dens;
    int unsigned     pick;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CfgKeep;
    cfg_wdata_i     <= '0;
    pdm_if.valid    <= 1'b0;
    pdm_if.pdm_word <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes and bit patterns under reset settings,
    // long enough to close the first block
    directed_words = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h00FF, 16'hFF00,
                       16'hAAAA, 16'h5555, 16'h7FFF, 16'hFFFE, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hF0F0,
                       16'h0F0F, 16'hFFFF, 16'h0000, 16'hFFFF};
    foreach (directed_words[i]) send_word(directed_words[i]);
    drain(8);

    // Random phases, each under its own register setting
    for (int p = 0; p < NumPhases; p++) begin
      if (p < 4) begin
        src_gap_pct    = 15;
        sink_stall_pct = 57;
      end else if (p < 8) begin
        src_gap_pct    = 57;
        sink_stall_pct = 15;
      end else begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end
      keep_v = $urandom_range(40000, 65535);
      pick   = $urandom_range(0, 5);
      win_v  = (pick == 5) ? 65535 : pick;
      thr_v  = ($urandom_range(0, 9) == 0) ? 32'h00FF_FFFF : $urandom_range(0, 3000);
      case (p)
        0: begin
          // full-scale keep, one-block windows, zero threshold
          keep_v = 65535;
          win_v  = 1;
          thr_v  = 0;
        end
        1: begin
          // zero keep, zero window acts as one, top threshold
          keep_v = 0;
          win_v  = 0;
          thr_v  = 32'h00FF_FFFF;
        end
        2: begin
          keep_v = 32'(KeepReset);
          win_v  = 2;
        end
        // long window so the block count runs up, then cut it short
        3: win_v = 65535;
        4: win_v = 1;
        default: ;
      endcase
      write_regs(keep_v[KeepW-1:0], win_v[WinW-1:0], thr_v[ThreshW-1:0]);

      dens = 8;
      for (int i = 0; i < PhaseWords; i++) begin
        // loud or quiet passages, one density per block
        if (i % BlockWordsDef == 0) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) dens = $urandom_range(13, 16);
          else if (pick < 7) dens = $urandom_range(0, 3);
          else dens = $urandom_range(0, 16);
        end
        if ($urandom_range(0, 9) == 0) send_word(PdmW'($urandom));
        else send_word(pdm_burst(dens));
      end
      drain(8);
    end

    drain(20);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
